// ----- sv/ahw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ahw_pkg;

    localparam int TIME_W = 32;
    localparam int HOLD_W = 16;
    localparam int HDR_W = 8;
    localparam int CFG_INDEX_W = 2;

    localparam logic [HOLD_W-1:0] ARM_HOLD_RESET = 16'd3500;
    localparam logic [HOLD_W-1:0] DISARM_HOLD_RESET = 16'd100;
    localparam logic [HOLD_W-1:0] HB_TIMEOUT_RESET = 16'd3100;

    localparam int HDR_ARM_BIT = 0;
    localparam int HDR_DISARM_BIT = 1;
    localparam int HDR_HB_BIT = 2;
    localparam int HDR_VALID_BIT = 7;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ARM_HOLD = 2'd0,
        CFG_DISARM_HOLD = 2'd1,
        CFG_HB_TIMEOUT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic [HDR_W-1:0]  header_byte;
    } in_item_t;

    typedef struct packed {
        logic output_enable;
        logic heartbeat_alive;
        logic armed;
    } out_item_t;

endpackage

`default_nettype wire

// ----- sv/arming_interlock_heartbeat_watchdog.sv -----
`timescale 1ns / 1ps
`default_nettype none

// An accepted input is held in the input register; its result is registered when the output register is free.
// Throughput: one item per cycle; a stalled result lets one more input in, then in_ready drops.
// The whole step is one pass of compares and 32-bit subtracts between those registers.
// Reset is asynchronous and active low: all state but the data registers clears, time of reset counts as zero,
// and the hold and timeout registers return to 3500, 100 and 3100 ms.

module arming_interlock_heartbeat_watchdog (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire ahw_pkg::in_item_t                     in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output ahw_pkg::out_item_t                         out_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ahw_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [ahw_pkg::HOLD_W-1:0]            cfg_data
);

    logic [ahw_pkg::HOLD_W-1:0] arm_hold_reg;
    logic [ahw_pkg::HOLD_W-1:0] disarm_hold_reg;
    logic [ahw_pkg::HOLD_W-1:0] hb_timeout_reg;

    logic              in_valid_reg;
    ahw_pkg::in_item_t in_item_reg;
    logic               out_valid_reg;
    ahw_pkg::out_item_t out_item_reg;

    logic                       arm_level_reg;
    logic                       disarm_level_reg;
    logic                       hb_level_reg;
    logic                       arm_prev_reg;
    logic                       disarm_prev_reg;
    logic [ahw_pkg::TIME_W-1:0] arm_press_reg;
    logic [ahw_pkg::TIME_W-1:0] disarm_press_reg;
    logic [ahw_pkg::TIME_W-1:0] last_hb_reg;
    logic                       expected_hb_reg;
    logic                       hb_ok_reg;
    logic                       arm_flag_reg;

    logic                       advance;
    logic                       arm_level_next;
    logic                       disarm_level_next;
    logic                       hb_level_next;
    logic [ahw_pkg::TIME_W-1:0] arm_press_next;
    logic [ahw_pkg::TIME_W-1:0] disarm_press_next;
    logic                       arm_fire;
    logic                       disarm_fire;
    logic [ahw_pkg::TIME_W-1:0] hb_age;
    logic                       hb_match;
    logic                       hb_ok_next;
    logic                       arm_flag_next;
    ahw_pkg::out_item_t         out_item_next;

    assign cfg_ready = 1'b1;
    assign advance = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_item_reg;

    always_comb
    begin
        if (in_item_reg.header_byte[ahw_pkg::HDR_VALID_BIT])
        begin
            arm_level_next = in_item_reg.header_byte[ahw_pkg::HDR_ARM_BIT];
            disarm_level_next = in_item_reg.header_byte[ahw_pkg::HDR_DISARM_BIT];
            hb_level_next = in_item_reg.header_byte[ahw_pkg::HDR_HB_BIT];
        end
        else
        begin
            arm_level_next = arm_level_reg;
            disarm_level_next = disarm_level_reg;
            hb_level_next = hb_level_reg;
        end
    end

    ahw_hold u_arm_hold (
        .level           (arm_level_next),
        .prev_level      (arm_prev_reg),
        .press_time      (arm_press_reg),
        .now_ms          (in_item_reg.now_ms),
        .hold_ms         (arm_hold_reg),
        .press_time_next (arm_press_next),
        .fire            (arm_fire)
    );

    ahw_hold u_disarm_hold (
        .level           (disarm_level_next),
        .prev_level      (disarm_prev_reg),
        .press_time      (disarm_press_reg),
        .now_ms          (in_item_reg.now_ms),
        .hold_ms         (disarm_hold_reg),
        .press_time_next (disarm_press_next),
        .fire            (disarm_fire)
    );

    always_comb
    begin
        hb_age = in_item_reg.now_ms - last_hb_reg;
        hb_match = (hb_level_next == expected_hb_reg);
        if (hb_match)
        begin
            hb_ok_next = 1'b1;
        end
        else if (hb_age > {{(ahw_pkg::TIME_W - ahw_pkg::HOLD_W){1'b0}}, hb_timeout_reg})
        begin
            hb_ok_next = 1'b0;
        end
        else
        begin
            hb_ok_next = hb_ok_reg;
        end

        arm_flag_next = arm_flag_reg;
        if (arm_fire)
        begin
            arm_flag_next = 1'b1;
        end
        if (disarm_fire || !hb_ok_next)
        begin
            arm_flag_next = 1'b0;
        end

        out_item_next.output_enable = hb_ok_next && arm_flag_next;
        out_item_next.heartbeat_alive = hb_ok_next;
        out_item_next.armed = arm_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_hold_reg <= ahw_pkg::ARM_HOLD_RESET;
            disarm_hold_reg <= ahw_pkg::DISARM_HOLD_RESET;
            hb_timeout_reg <= ahw_pkg::HB_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (ahw_pkg::cfg_index_t'(cfg_index))
                ahw_pkg::CFG_ARM_HOLD:    arm_hold_reg <= cfg_data;
                ahw_pkg::CFG_DISARM_HOLD: disarm_hold_reg <= cfg_data;
                ahw_pkg::CFG_HB_TIMEOUT:  hb_timeout_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arm_level_reg <= 1'b0;
            disarm_level_reg <= 1'b0;
            hb_level_reg <= 1'b0;
            arm_prev_reg <= 1'b0;
            disarm_prev_reg <= 1'b0;
            arm_press_reg <= '0;
            disarm_press_reg <= '0;
            last_hb_reg <= '0;
            expected_hb_reg <= 1'b0;
            hb_ok_reg <= 1'b0;
            arm_flag_reg <= 1'b0;
        end
        else if (advance)
        begin
            arm_level_reg <= arm_level_next;
            disarm_level_reg <= disarm_level_next;
            hb_level_reg <= hb_level_next;
            arm_prev_reg <= arm_level_next;
            disarm_prev_reg <= disarm_level_next;
            arm_press_reg <= arm_press_next;
            disarm_press_reg <= disarm_press_next;
            if (hb_match)
            begin
                last_hb_reg <= in_item_reg.now_ms;
                expected_hb_reg <= !expected_hb_reg;
            end
            hb_ok_reg <= hb_ok_next;
            arm_flag_reg <= arm_flag_next;
        end
    end

    // The arming flag never survives a lost heartbeat.
    assert property (@(posedge clk) disable iff (!rst_n) !hb_ok_reg |-> !arm_flag_reg)
        else $error("arming flag set while heartbeat is lost");

    // A step always leaves a result waiting in the output register.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> out_valid_reg)
        else $error("step did not produce a result");

    // The offered result agrees with the state that produced it.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (out_item_reg.armed == arm_flag_reg)
                    && (out_item_reg.heartbeat_alive == hb_ok_reg))
        else $error("result does not match updated state");

    // Output enable is exactly heartbeat alive and armed.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.output_enable
                           == (out_item_reg.heartbeat_alive && out_item_reg.armed)))
        else $error("output enable inconsistent with its terms");

endmodule

`default_nettype wire

// ----- sv/ahw_hold.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ahw_hold (
    input  wire logic                          level,
    input  wire logic                          prev_level,
    input  wire logic [ahw_pkg::TIME_W-1:0]    press_time,
    input  wire logic [ahw_pkg::TIME_W-1:0]    now_ms,
    input  wire logic [ahw_pkg::HOLD_W-1:0]    hold_ms,
    output logic [ahw_pkg::TIME_W-1:0]         press_time_next,
    output logic                               fire
);

    logic [ahw_pkg::TIME_W-1:0] held_ms;

    always_comb
    begin
        press_time_next = (!prev_level && level) ? now_ms : press_time;
        held_ms = now_ms - press_time_next;
        fire = level && (held_ms > {{(ahw_pkg::TIME_W - ahw_pkg::HOLD_W){1'b0}}, hold_ms});
    end

endmodule

`default_nettype wire
